// ===== rtl/coalesced_hash_map_defines.svh =====
// Assertion macros for the coalesced hash map.
`ifndef COALESCED_HASH_MAP_DEFINES_SVH
`define COALESCED_HASH_MAP_DEFINES_SVH

`ifndef SYNTH
// Condition holds at every clock edge out of reset
`define CHM_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("chm check failed");
// Trigger implies a condition in the following cycle
`define CHM_ASSERT_NEXT(lbl, clk, rstn, trig, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (prop)) \
        else $error("chm sequence check failed");
`else
`define CHM_ASSERT(lbl, clk, rstn, prop)
`define CHM_ASSERT_NEXT(lbl, clk, rstn, trig, prop)
`endif

`endif

// ===== rtl/chm_pkg.sv =====
`timescale 1ns / 1ps
package chm_pkg;
    localparam int TABLE_SLOTS = 256;
    localparam int SLOT_BITS   = $clog2(TABLE_SLOTS);
    localparam int LINK_BITS   = SLOT_BITS + 1;
    localparam int KEY_BITS    = 64;
    localparam int HASH_BITS   = 32;
    localparam int VALUE_BITS  = 32;
    localparam int COUNT_BITS  = 9;

    // response status codes
    localparam logic [1:0] ST_HIT      = 2'd0;
    localparam logic [1:0] ST_MISS     = 2'd1;
    localparam logic [1:0] ST_INSERTED = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    // one table slot
    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [HASH_BITS-1:0]  hash;
        logic [VALUE_BITS-1:0] value;
        logic [LINK_BITS-1:0]  link;
    } t_entry;

    // controller to memory access
    typedef struct packed {
        logic                 rd_en;
        logic [SLOT_BITS-1:0] rd_addr;
        logic                 wr_en;
        logic [SLOT_BITS-1:0] wr_addr;
        t_entry               wr_data;
    } t_tbl_req;

    // controller status for checks
    typedef struct packed {
        logic                  busy;
        logic [COUNT_BITS-1:0] count;
    } t_ctrl_stat;
endpackage

// ===== rtl/chm_if.sv =====
`timescale 1ns / 1ps
interface chm_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [31:0] key_hash;
    logic [63:0] key_word;
    logic [31:0] put_value;
    modport source(output valid, req_type, key_hash, key_word, put_value, input ready);
    modport sink(input valid, req_type, key_hash, key_word, put_value, output ready);
endinterface

interface chm_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] read_value;
    logic [8:0]  entry_count;
    modport source(output valid, status, read_value, entry_count, input ready);
    modport sink(input valid, status, read_value, entry_count, output ready);
endinterface

// ===== rtl/chm_table.sv =====
`timescale 1ns / 1ps
module chm_table (
    input  logic              i_clk,
    input  chm_pkg::t_tbl_req i_req,
    output chm_pkg::t_entry   o_rd_data
);
    chm_pkg::t_entry r_mem [chm_pkg::TABLE_SLOTS];
    chm_pkg::t_entry r_rd_data;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ===== rtl/chm_ctrl.sv =====
`timescale 1ns / 1ps
module chm_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    chm_req_if.sink              i_req,
    chm_rsp_if.source            o_rsp,
    input  chm_pkg::t_entry      i_rd_data,
    output chm_pkg::t_tbl_req    o_tbl,
    output chm_pkg::t_ctrl_stat  o_stat
);
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ   = 3'd1;
    localparam logic [2:0] S_SEARCH = 3'd2;
    localparam logic [2:0] S_LINK   = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    localparam int SB = chm_pkg::SLOT_BITS;
    localparam int LB = chm_pkg::LINK_BITS;
    localparam int CB = chm_pkg::COUNT_BITS;

    logic [2:0] r_state, n_state;
    logic [chm_pkg::TABLE_SLOTS-1:0] r_used, n_used;
    logic [CB-1:0] r_total, n_total;
    logic          r_put, n_put;
    logic [chm_pkg::HASH_BITS-1:0]  r_hash, n_hash;
    logic [chm_pkg::KEY_BITS-1:0]   r_key, n_key;
    logic [chm_pkg::VALUE_BITS-1:0] r_val, n_val;
    logic [SB-1:0] r_cur, n_cur;
    logic [LB-1:0] r_steps, n_steps;
    logic [SB-1:0] r_idx, n_idx;
    logic [SB-1:0] r_scan, n_scan;
    chm_pkg::t_entry r_tail, n_tail;
    logic [1:0]  r_res_st, n_res_st;
    logic [chm_pkg::VALUE_BITS-1:0] r_res_rv, n_res_rv;
    logic        r_out_valid, n_out_valid;
    logic [1:0]  r_out_st, n_out_st;
    logic [chm_pkg::VALUE_BITS-1:0] r_out_rv, n_out_rv;
    logic [CB-1:0] r_out_cnt, n_out_cnt;

    logic [SB-1:0] w_home;
    logic [LB-1:0] w_steps_inc;
    logic          w_match;
    logic          w_tail;
    chm_pkg::t_entry w_fill;

    assign w_home      = i_req.key_hash[SB-1:0];
    assign w_steps_inc = r_steps + LB'(1);
    assign w_match     = (i_rd_data.hash == r_hash) && (i_rd_data.key == r_key);
    assign w_tail      = i_rd_data.link[SB] || !r_used[i_rd_data.link[SB-1:0]]
                         || w_steps_inc[SB];

    // fresh slot contents, no link
    always_comb begin
        w_fill.key   = r_key;
        w_fill.hash  = r_hash;
        w_fill.value = r_val;
        w_fill.link  = LB'(chm_pkg::TABLE_SLOTS);
    end

    // request sequencer
    always_comb begin
        n_state = r_state;   n_used = r_used;   n_total = r_total;
        n_put = r_put;       n_hash = r_hash;   n_key = r_key;    n_val = r_val;
        n_cur = r_cur;       n_steps = r_steps; n_idx = r_idx;    n_scan = r_scan;
        n_tail = r_tail;     n_res_st = r_res_st; n_res_rv = r_res_rv;
        n_out_valid = r_out_valid; n_out_st = r_out_st;
        n_out_rv = r_out_rv; n_out_cnt = r_out_cnt;
        o_tbl = '0;
        o_tbl.wr_data = w_fill;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_put  = i_req.req_type;
                    n_hash = i_req.key_hash;
                    n_key  = i_req.key_word;
                    n_val  = i_req.put_value;
                    n_cur  = w_home;
                    n_steps = '0;
                    n_res_rv = '0;
                    if (!r_used[w_home]) begin
                        if (i_req.req_type) begin
                            o_tbl.wr_en = 1'b1;
                            o_tbl.wr_addr = w_home;
                            o_tbl.wr_data.key   = i_req.key_word;
                            o_tbl.wr_data.hash  = i_req.key_hash;
                            o_tbl.wr_data.value = i_req.put_value;
                            n_used[w_home] = 1'b1;
                            n_total = r_total + CB'(1);
                            n_res_st = chm_pkg::ST_INSERTED;
                        end else begin
                            n_res_st = chm_pkg::ST_MISS;
                        end
                        n_state = S_DONE;
                    end else begin
                        o_tbl.rd_en = 1'b1;
                        o_tbl.rd_addr = w_home;
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                if (w_match) begin
                    n_res_st = chm_pkg::ST_HIT;
                    if (r_put) begin
                        o_tbl.wr_en = 1'b1;
                        o_tbl.wr_addr = r_cur;
                        o_tbl.wr_data = i_rd_data;
                        o_tbl.wr_data.value = r_val;
                    end else begin
                        n_res_rv = i_rd_data.value;
                    end
                    n_state = S_DONE;
                end else if (w_tail) begin
                    if (!r_put) begin
                        n_res_st = chm_pkg::ST_MISS;
                        n_state = S_DONE;
                    end else if (w_steps_inc[SB]) begin
                        n_res_st = chm_pkg::ST_FULL;
                        n_state = S_DONE;
                    end else begin
                        n_tail = i_rd_data;
                        n_idx  = r_cur + SB'(1);
                        n_scan = SB'(1);
                        n_state = S_SEARCH;
                    end
                end else begin
                    o_tbl.rd_en = 1'b1;
                    o_tbl.rd_addr = i_rd_data.link[SB-1:0];
                    n_cur = i_rd_data.link[SB-1:0];
                    n_steps = w_steps_inc;
                end
            end
            S_SEARCH: begin
                // one slot probed per cycle, wrapping at the table end
                if (!r_used[r_idx]) begin
                    o_tbl.wr_en = 1'b1;
                    o_tbl.wr_addr = r_idx;
                    n_used[r_idx] = 1'b1;
                    n_total = r_total + CB'(1);
                    n_state = S_LINK;
                end else if (r_scan == SB'(chm_pkg::TABLE_SLOTS - 1)) begin
                    n_res_st = chm_pkg::ST_FULL;
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + SB'(1);
                    n_scan = r_scan + SB'(1);
                end
            end
            S_LINK: begin
                // hook the new slot onto the old tail
                o_tbl.wr_en = 1'b1;
                o_tbl.wr_addr = r_cur;
                o_tbl.wr_data = r_tail;
                o_tbl.wr_data.link = {1'b0, r_idx};
                n_res_st = chm_pkg::ST_INSERTED;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_st = r_res_st;
                    n_out_rv = r_res_rv;
                    n_out_cnt = r_total;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used <= '0;
            r_total <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used <= n_used;
            r_total <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_put <= n_put;     r_hash <= n_hash;   r_key <= n_key;   r_val <= n_val;
        r_cur <= n_cur;     r_steps <= n_steps; r_idx <= n_idx;   r_scan <= n_scan;
        r_tail <= n_tail;   r_res_st <= n_res_st; r_res_rv <= n_res_rv;
        r_out_st <= n_out_st; r_out_rv <= n_out_rv; r_out_cnt <= n_out_cnt;
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.status = r_out_st;
    assign o_rsp.read_value = r_out_rv;
    assign o_rsp.entry_count = r_out_cnt;
    assign o_stat.busy = (r_state != S_IDLE);
    assign o_stat.count = r_total;
endmodule

// ===== rtl/coalesced_hash_map.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Payload
// i_req    in   req_type, key_hash, key_word, put_value
// o_rsp    out  status, read_value, entry_count
//
// A request into a free home slot needs no table read; otherwise a chain walk
// reads one slot at a time from the table memory (one read port, registered).
// An insert behind a chain then probes slots in turn and links the new slot.
// Synchronous active-low reset clears occupancy and count; no clear pass.
// A new request is taken while the previous response waits on o_rsp; the
// next one then holds in its last cycle until that response is taken.
`include "coalesced_hash_map_defines.svh"
module coalesced_hash_map (
    input  logic       i_clk,
    input  logic       i_rst_n,
    chm_req_if.sink    i_req,
    chm_rsp_if.source  o_rsp
);
    chm_pkg::t_tbl_req   w_tbl;
    chm_pkg::t_entry     w_rd_data;
    chm_pkg::t_ctrl_stat w_stat;
    logic                w_rv_ok;

    chm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_rsp     (o_rsp),
        .i_rd_data (w_rd_data),
        .o_tbl     (w_tbl),
        .o_stat    (w_stat)
    );

    chm_table u_table (
        .i_clk     (i_clk),
        .i_req     (w_tbl),
        .o_rd_data (w_rd_data)
    );

    // read value is zero unless a hit
    assign w_rv_ok = (o_rsp.status == chm_pkg::ST_HIT) || (o_rsp.read_value == 32'd0);

    `CHM_ASSERT(a_count_bound, i_clk, i_rst_n, w_stat.count <= 9'd256)
    `CHM_ASSERT(a_zero_value, i_clk, i_rst_n, !o_rsp.valid || w_rv_ok)
    `CHM_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_req.valid && i_req.ready, w_stat.busy)
endmodule

// ===== test/coalesced_hash_map_tb.sv =====
`timescale 1ns / 1ps
module coalesced_hash_map_tb;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_LEN = 300;

    // one request as offered on the input channel
    typedef struct {
        logic        put;
        logic [31:0] hash;
        logic [63:0] key;
        logic [31:0] value;
    } t_map_req;

    // one response of the map
    typedef struct {
        logic [1:0]  status;
        logic [31:0] read_value;
        logic [8:0]  entry_count;
    } t_map_rsp;

    // shadow of the map; predicts the response of each accepted request
    class map_scoreboard;
        bit              used[chm_pkg::TABLE_SLOTS];
        logic [63:0]     keys[chm_pkg::TABLE_SLOTS];
        logic [31:0]     hashes[chm_pkg::TABLE_SLOTS];
        logic [31:0]     values[chm_pkg::TABLE_SLOTS];
        int unsigned     links[chm_pkg::TABLE_SLOTS];
        int unsigned     occupied;
        t_map_rsp        pending_rsp[$];
        int              mismatches;

        function void clear();
            for (int i = 0; i < chm_pkg::TABLE_SLOTS; i++) begin
                used[i] = 0;
                links[i] = chm_pkg::TABLE_SLOTS;
            end
            occupied = 0;
        endfunction

        function void claim(int unsigned s, t_map_req r);
            used[s] = 1;
            keys[s] = r.key;
            hashes[s] = r.hash;
            values[s] = r.value;
            links[s] = chm_pkg::TABLE_SLOTS;
            occupied++;
        endfunction

        // predict the response of one accepted request and update the shadow
        function void note_request(t_map_req r);
            t_map_rsp    e;
            int unsigned cur;
            int unsigned nx;
            int unsigned steps;
            int unsigned s;
            cur = r.hash & (chm_pkg::TABLE_SLOTS - 1);
            e.status = chm_pkg::ST_MISS;
            e.read_value = '0;
            steps = 0;
            if (!used[cur]) begin
                if (r.put) begin
                    claim(cur, r);
                    e.status = chm_pkg::ST_INSERTED;
                end
            end else begin
                forever begin
                    if (hashes[cur] == r.hash && keys[cur] == r.key) begin
                        if (r.put) values[cur] = r.value;
                        else e.read_value = values[cur];
                        e.status = chm_pkg::ST_HIT;
                        break;
                    end
                    nx = links[cur];
                    steps++;
                    if (nx >= chm_pkg::TABLE_SLOTS || !used[nx] ||
                        steps >= chm_pkg::TABLE_SLOTS) begin
                        if (r.put) begin
                            e.status = chm_pkg::ST_FULL;
                            if (steps < chm_pkg::TABLE_SLOTS) begin
                                for (int i = 1; i < chm_pkg::TABLE_SLOTS; i++) begin
                                    s = (cur + i) % chm_pkg::TABLE_SLOTS;
                                    if (!used[s]) begin
                                        links[cur] = s;
                                        claim(s, r);
                                        e.status = chm_pkg::ST_INSERTED;
                                        break;
                                    end
                                end
                            end
                        end
                        break;
                    end
                    cur = nx;
                end
            end
            e.entry_count = occupied[8:0];
            pending_rsp.push_back(e);
        endfunction

        function void check_response(t_map_rsp a);
            t_map_rsp e;
            if (pending_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response status=%0d value=%h count=%0d",
                             a.status, a.read_value, a.entry_count);
                return;
            end
            e = pending_rsp.pop_front();
            if (a.status !== e.status || a.read_value !== e.read_value ||
                a.entry_count !== e.entry_count) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp st=%0d val=%h cnt=%0d, got st=%0d val=%h cnt=%0d",
                             e.status, e.read_value, e.entry_count,
                             a.status, a.read_value, a.entry_count);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    chm_req_if req_ch();
    chm_rsp_if rsp_ch();

    coalesced_hash_map uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_req(req_ch.sink),
        .o_rsp(rsp_ch.source)
    );

    map_scoreboard sb;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_cycles = 0;
    int  idle_cycles = 0;
    bit  timed_out = 0;
    event hold_go;
    // recently used keys, so that random requests hit and collide
    logic [63:0] key_pool[$];
    logic [31:0] hash_pool[$];

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // long receiver hold-off, counted in its own process
    initial begin
        forever begin
            @(hold_go);
            hold_cycles <= HOLD_LEN;
            @(posedge i_clk);
            while (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                @(posedge i_clk);
            end
        end
    end

    // receiver: random stalls, plus the long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // sample both channels; the scoreboard sees each request once
    always @(posedge i_clk) begin
        t_map_req r;
        t_map_rsp a;
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                r.put = req_ch.req_type;
                r.hash = req_ch.key_hash;
                r.key = req_ch.key_word;
                r.value = req_ch.put_value;
                sb.note_request(r);
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                a.status = rsp_ch.status;
                a.read_value = rsp_ch.read_value;
                a.entry_count = rsp_ch.entry_count;
                sb.check_response(a);
            end
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // offer one request and hold it until taken; valid drops only when idle
    task automatic send_request(t_map_req r);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= r.put;
        req_ch.key_hash <= r.hash;
        req_ch.key_word <= r.key;
        req_ch.put_value <= r.value;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_fields(logic put, logic [31:0] h, logic [63:0] k, logic [31:0] v);
        t_map_req r;
        r.put = put;
        r.hash = h;
        r.key = k;
        r.value = v;
        send_request(r);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (sb.pending_rsp.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // mostly reuse known keys; small hash range forces long chains
    task automatic send_random(int n, int hash_span);
        t_map_req r;
        int       pick;
        for (int i = 0; i < n; i++) begin
            if (key_pool.size() > 0 && $urandom_range(99) < 55) begin
                pick = $urandom_range(key_pool.size() - 1);
                r.key = key_pool[pick];
                r.hash = hash_pool[pick];
                // same key, different hash: must not match
                if ($urandom_range(19) == 0) r.hash = r.hash ^ 32'h100;
            end else begin
                r.key = {$urandom, $urandom};
                r.hash = ($urandom & 32'hFFFF_FF00) | 32'($urandom_range(hash_span - 1));
                if (key_pool.size() < 600) begin
                    key_pool.push_back(r.key);
                    hash_pool.push_back(r.hash);
                end
            end
            r.put = ($urandom_range(99) < 55);
            r.value = $urandom;
            send_request(r);
        end
    endtask

    initial begin
        sb = new();
        sb.clear();
        sb.mismatches = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        req_ch.valid = 1'b0;
        req_ch.req_type = 1'b0;
        req_ch.key_hash = '0;
        req_ch.key_word = '0;
        req_ch.put_value = '0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty lookup, insert, hit, update, collisions, wrap, extremes
        send_fields(1'b0, 32'h0000_0005, 64'h1, 32'h0);
        send_fields(1'b1, 32'h0000_0005, 64'h1, 32'hFFFF_FFFF);
        send_fields(1'b0, 32'h0000_0005, 64'h1, 32'h0);
        send_fields(1'b1, 32'h0000_0005, 64'h1, 32'h1234_5678);
        send_fields(1'b0, 32'h0000_0005, 64'h1, 32'h0);
        send_fields(1'b1, 32'hFFFF_FF05, 64'h1, 32'hA5A5_A5A5);
        send_fields(1'b0, 32'hFFFF_FF05, 64'h1, 32'h0);
        send_fields(1'b1, 32'h0000_0005, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
        send_fields(1'b0, 32'h0000_0005, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_fields(1'b0, 32'h0000_0005, 64'h2, 32'h0);
        send_fields(1'b1, 32'h0000_00FF, 64'h0, 32'h0000_0001);
        send_fields(1'b1, 32'hFFFF_FFFF, 64'h3, 32'h8000_0000);
        send_fields(1'b1, 32'h0000_01FF, 64'h4, 32'h7FFF_FFFF);
        send_fields(1'b0, 32'h0000_01FF, 64'h4, 32'h0);
        send_fields(1'b0, 32'h0000_00FF, 64'h0, 32'h0);
        send_fields(1'b0, 32'hAAAA_AA00, 64'h5555_5555_5555_5555, 32'h0);
        wait_drained();

        // phase sweep of idling patterns
        send_random(200, 256);
        send_idle_pct = 45;
        send_random(150, 16);
        send_idle_pct = 0;
        recv_stall_pct = 45;
        send_random(150, 256);
        send_idle_pct = 9;
        recv_stall_pct = 9;
        send_random(150, 4);

        // long receiver hold-off while requests keep coming
        send_idle_pct = 0;
        recv_stall_pct = 0;
        -> hold_go;
        send_random(40, 256);
        wait_drained();

        // fill the table to exercise the full case and wrap-around probing
        for (int i = 0; i < 300; i++)
            send_fields(1'b1, {24'h0, 8'($urandom_range(3))} | ($urandom & 32'hFFFF_FF00),
                        {32'hF0F0_0000, 32'(i)}, $urandom);
        send_fields(1'b1, 32'h0, 64'hF0F0_0000_0000_0000, 32'hDEAD_BEEF);
        send_idle_pct = 45;
        recv_stall_pct = 45;
        send_random(120, 256);
        wait_drained();

        while (sb.pending_rsp.size() != 0 && !timed_out) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_rsp.size() == 0 && !timed_out)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1;
            $display("RESULT: ERROR");
            $finish;
        end
    end
endmodule
